### sv/gprm_pkg.sv
`timescale 1ns / 1ps
package gprm_pkg;

	localparam int MaxFrameLen = 32;
	localparam int ReportLen   = 24;
	localparam int LenW        = 6;
	localparam int IdxW        = $clog2(ReportLen);
	localparam int FrameW      = ReportLen * 8;
	localparam int LimW        = 17;
	localparam int DzFull      = 32767;
	localparam int DzPct       = 100;
	localparam int DzReset     = 5;
	localparam int DzShift     = 30;
	localparam longint DzRecip = ((64'd1 << DzShift) + DzPct - 1) / DzPct;

	localparam logic [7:0] START_MARK = 8'hAA;
	localparam logic [7:0] PACK_HALF  = 8'd128;

	// parser phases
	localparam logic [1:0] PH_START   = 2'd0;
	localparam logic [1:0] PH_LEN     = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;
	localparam logic [1:0] PH_CHECK   = 2'd3;

	// register indexes
	localparam logic [2:0] CFG_DZ_L   = 3'd0;
	localparam logic [2:0] CFG_DZ_R   = 3'd1;
	localparam logic [2:0] CFG_FLIP_LX = 3'd2;
	localparam logic [2:0] CFG_FLIP_LY = 3'd3;
	localparam logic [2:0] CFG_FLIP_RX = 3'd4;
	localparam logic [2:0] CFG_FLIP_RY = 3'd5;
	localparam logic [2:0] CFG_MODE   = 3'd6;

	// report modes
	localparam logic [1:0] MODE_S16  = 2'd0;
	localparam logic [1:0] MODE_HAT  = 2'd1;
	localparam logic [1:0] MODE_PACK = 2'd2;
	localparam logic [1:0] MODE_RSVD = 2'd3;

	// hat codes
	localparam logic [3:0] HAT_UP      = 4'd0;
	localparam logic [3:0] HAT_UP_R    = 4'd1;
	localparam logic [3:0] HAT_RIGHT   = 4'd2 + 4'd2;
	localparam logic [3:0] HAT_DN_R    = 4'd3;
	localparam logic [3:0] HAT_DOWN    = 4'd2;
	localparam logic [3:0] HAT_DN_L    = 4'd5;
	localparam logic [3:0] HAT_LEFT    = 4'd6;
	localparam logic [3:0] HAT_UP_L    = 4'd7;
	localparam logic [3:0] HAT_NEUTRAL = 4'd8;

	typedef logic [FrameW-1:0] frame_t;

	typedef struct packed {
		logic [LimW-1:0] lim_l;
		logic [LimW-1:0] lim_r;
		logic            flip_lx;
		logic            flip_ly;
		logic            flip_rx;
		logic            flip_ry;
		logic [1:0]      mode;
	} cfg_t;

	// percent to limit, divide by reciprocal multiplication
	function automatic logic [LimW-1:0] dz_limit(input logic [7:0] dz);
		logic [22:0] p;
		logic [46:0] t;
		p = 23'(dz) * 23'(DzFull);
		t = 47'(p) * 47'(DzRecip);
		return t[DzShift+LimW-1:DzShift];
	endfunction

	function automatic logic [3:0] hat_of(input logic [15:0] b);
		logic [3:0] h;
		if (b[4])
			h = b[6] ? HAT_UP_L : (b[7] ? HAT_UP_R : HAT_UP);
		else if (b[5])
			h = b[6] ? HAT_DN_L : (b[7] ? HAT_DN_R : HAT_DOWN);
		else if (b[6])
			h = HAT_LEFT;
		else if (b[7])
			h = HAT_RIGHT;
		else
			h = HAT_NEUTRAL;
		return h;
	endfunction

	function automatic logic [15:0] dz_apply(input logic [15:0] raw, input logic [LimW-1:0] lim);
		logic [16:0] mag;
		mag = raw[15] ? (17'h1_0000 - {1'b0, raw}) : {1'b0, raw};
		return (mag < lim) ? 16'h0000 : raw;
	endfunction

	function automatic logic [15:0] stick_out(input logic [15:0] v, input logic flip,
			input logic [1:0] mode);
		logic [15:0] f;
		logic [16:0] m;
		logic [7:0]  q;
		f = flip ? (16'h0000 - v) : v;
		m = 17'h1_0000 - {1'b0, f};
		if (f[15])
			q = 8'(9'd0 - m[16:8]) + PACK_HALF;
		else
			q = f[15:8] + PACK_HALF;
		return (mode == MODE_PACK) ? {8'h00, q} : f;
	endfunction

endpackage

### sv/framed_gamepad_report_mapper.sv
`timescale 1ns / 1ps
// Framed gamepad report mapper. Takes one received byte per cycle and deframes 0xAA, a length
// byte, the payload and a sum checksum; a good 24-byte frame gives one report, which passes from
// the frame queue through a two-stage back end (deadzone, then flip and packing).
// Input is held off only while the two-entry frame queue between parser and back end is full,
// so a byte is taken every cycle as long as reports are collected. Register writes are always
// ready and apply from the next cycle.
module framed_gamepad_report_mapper (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] stick_lx,
	output logic signed [15:0] stick_ly,
	output logic signed [15:0] stick_rx,
	output logic signed [15:0] stick_ry,
	output logic [7:0]         left_trigger,
	output logic [7:0]         right_trigger,
	output logic [15:0]        button_bits,
	output logic [3:0]         hat_dir,
	output logic [47:0]        gyro_xyz,
	output logic [47:0]        accel_xyz,
	output logic [1:0]         format_used,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [7:0]         cfg_data
);
	import gprm_pkg::*;

	logic [LimW-1:0] lim_l_q, lim_r_q;
	logic            flip_lx_q, flip_ly_q, flip_rx_q, flip_ry_q;
	logic [1:0]      mode_q;
	cfg_t            cfg;

	logic   push, full, pop, nempty;
	frame_t push_frame, head;

	logic [15:0] lx, ly, rx, ry;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_l_q   <= dz_limit(8'(DzReset));
			lim_r_q   <= dz_limit(8'(DzReset));
			flip_lx_q <= 1'b0;
			flip_ly_q <= 1'b1;
			flip_rx_q <= 1'b0;
			flip_ry_q <= 1'b1;
			mode_q    <= MODE_S16;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DZ_L:    lim_l_q   <= dz_limit(cfg_data);
				CFG_DZ_R:    lim_r_q   <= dz_limit(cfg_data);
				CFG_FLIP_LX: flip_lx_q <= cfg_data[0];
				CFG_FLIP_LY: flip_ly_q <= cfg_data[0];
				CFG_FLIP_RX: flip_rx_q <= cfg_data[0];
				CFG_FLIP_RY: flip_ry_q <= cfg_data[0];
				CFG_MODE:    mode_q    <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.lim_l   = lim_l_q;
		cfg.lim_r   = lim_r_q;
		cfg.flip_lx = flip_lx_q;
		cfg.flip_ly = flip_ly_q;
		cfg.flip_rx = flip_rx_q;
		cfg.flip_ry = flip_ry_q;
		cfg.mode    = (mode_q == MODE_RSVD) ? MODE_S16 : mode_q;
	end

	gprm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.full       (full),
		.push       (push),
		.push_frame (push_frame)
	);

	gprm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_frame),
		.full      (full),
		.pop       (pop),
		.nempty    (nempty),
		.head      (head)
	);

	gprm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (nempty),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.lx         (lx),
		.ly         (ly),
		.rx         (rx),
		.ry         (ry),
		.ltrig      (left_trigger),
		.rtrig      (right_trigger),
		.btn        (button_bits),
		.hat        (hat_dir),
		.gyro       (gyro_xyz),
		.accel      (accel_xyz),
		.fmt        (format_used)
	);

	assign stick_lx = $signed(lx);
	assign stick_ly = $signed(ly);
	assign stick_rx = $signed(rx);
	assign stick_ry = $signed(ry);

endmodule

### sv/gprm_front.sv
`timescale 1ns / 1ps
module gprm_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [7:0]      rx_byte,
	input  logic            full,
	output logic            push,
	output gprm_pkg::frame_t push_frame
);
	import gprm_pkg::*;

	logic [1:0]      phase_q;
	logic [LenW-1:0] len_q;
	logic [LenW-1:0] idx_q;
	logic [7:0]      sum_q;
	logic [7:0]      pay_q [ReportLen];

	logic            acc;
	logic            len_ok;
	logic [LenW-1:0] idx_nxt;

	assign in_stall = full;
	assign acc      = in_valid & ~full;
	assign idx_nxt  = idx_q + LenW'(1);

	always_comb begin
		len_ok = rx_byte inside {[8'd1 : 8'(MaxFrameLen)]};
	end

	assign push = acc && (phase_q == PH_CHECK) && (sum_q == rx_byte)
		&& (len_q == LenW'(ReportLen));

	always_comb begin
		for (int i = 0; i < ReportLen; i++)
			push_frame[i*8 +: 8] = pay_q[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			len_q   <= '0;
			idx_q   <= '0;
			sum_q   <= '0;
		end else if (acc) begin
			case (phase_q)
				PH_START: begin
					if (rx_byte == START_MARK)
						phase_q <= PH_LEN;
				end
				PH_LEN: begin
					len_q   <= rx_byte[LenW-1:0];
					idx_q   <= '0;
					sum_q   <= '0;
					phase_q <= len_ok ? PH_PAYLOAD : PH_START;
				end
				PH_PAYLOAD: begin
					sum_q <= sum_q + rx_byte;
					idx_q <= idx_nxt;
					if (idx_nxt == len_q)
						phase_q <= PH_CHECK;
				end
				default: begin
					phase_q <= PH_START;
				end
			endcase
		end
	end

	// payload capture, first report bytes only
	always_ff @(posedge clk) begin
		if (acc && (phase_q == PH_PAYLOAD) && (idx_q < LenW'(ReportLen)))
			pay_q[idx_q[IdxW-1:0]] <= rx_byte;
	end

endmodule

### sv/gprm_fifo.sv
`timescale 1ns / 1ps
module gprm_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  gprm_pkg::frame_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             nempty,
	output gprm_pkg::frame_t head
);
	import gprm_pkg::*;

	frame_t     mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full   = (cnt_q == 2'd2);
	assign nempty = (cnt_q != 2'd0);
	assign head   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

endmodule

### sv/gprm_back.sv
`timescale 1ns / 1ps
module gprm_back (
	input  logic             clk,
	input  logic             arst_n,
	input  gprm_pkg::cfg_t   cfg,
	input  logic             head_valid,
	input  gprm_pkg::frame_t head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [15:0]      lx,
	output logic [15:0]      ly,
	output logic [15:0]      rx,
	output logic [15:0]      ry,
	output logic [7:0]       ltrig,
	output logic [7:0]       rtrig,
	output logic [15:0]      btn,
	output logic [3:0]       hat,
	output logic [47:0]      gyro,
	output logic [47:0]      accel,
	output logic [1:0]       fmt
);
	import gprm_pkg::*;

	logic        valid_s1;
	logic [15:0] lx_s1, ly_s1, rx_s1, ry_s1;
	logic [7:0]  ltrig_s1, rtrig_s1;
	logic [15:0] btn_s1;
	logic [3:0]  hat_s1;
	logic [47:0] gyro_s1, accel_s1;

	logic        out_valid_q;
	logic [15:0] lx_q, ly_q, rx_q, ry_q;
	logic [7:0]  ltrig_q, rtrig_q;
	logic [15:0] btn_q;
	logic [3:0]  hat_q;
	logic [47:0] gyro_q, accel_q;
	logic [1:0]  fmt_q;

	logic out_adv;
	logic s1_take;

	assign out_adv = ~out_valid_q | ~out_stall;
	assign s1_take = ~valid_s1 | out_adv;
	assign pop     = head_valid & s1_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_take)
				valid_s1 <= head_valid;
			if (out_adv)
				out_valid_q <= valid_s1;
		end
	end

	// deadzone stage
	always_ff @(posedge clk) begin
		if (pop) begin
			lx_s1    <= dz_apply(head[15:0], cfg.lim_l);
			ly_s1    <= dz_apply(head[31:16], cfg.lim_l);
			rx_s1    <= dz_apply(head[47:32], cfg.lim_r);
			ry_s1    <= dz_apply(head[63:48], cfg.lim_r);
			ltrig_s1 <= head[71:64];
			rtrig_s1 <= head[79:72];
			btn_s1   <= head[95:80];
			hat_s1   <= hat_of(head[95:80]);
			gyro_s1  <= head[143:96];
			accel_s1 <= head[191:144];
		end
	end

	// flip and packing into the output register
	always_ff @(posedge clk) begin
		if (out_adv && valid_s1) begin
			lx_q    <= stick_out(lx_s1, cfg.flip_lx, cfg.mode);
			ly_q    <= stick_out(ly_s1, cfg.flip_ly, cfg.mode);
			rx_q    <= stick_out(rx_s1, cfg.flip_rx, cfg.mode);
			ry_q    <= stick_out(ry_s1, cfg.flip_ry, cfg.mode);
			ltrig_q <= ltrig_s1;
			rtrig_q <= rtrig_s1;
			btn_q   <= btn_s1;
			hat_q   <= hat_s1;
			gyro_q  <= gyro_s1;
			accel_q <= accel_s1;
			fmt_q   <= cfg.mode;
		end
	end

	assign out_valid = out_valid_q;
	assign lx        = lx_q;
	assign ly        = ly_q;
	assign rx        = rx_q;
	assign ry        = ry_q;
	assign ltrig     = ltrig_q;
	assign rtrig     = rtrig_q;
	assign btn       = btn_q;
	assign hat       = hat_q;
	assign gyro      = gyro_q;
	assign accel     = accel_q;
	assign fmt       = fmt_q;

endmodule

### sv/gprm_checker.sv
`timescale 1ns / 1ps
module gprm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] stick_lx,
	input logic signed [15:0] stick_ly,
	input logic signed [15:0] stick_rx,
	input logic signed [15:0] stick_ry,
	input logic [15:0]        button_bits,
	input logic [3:0]         hat_dir,
	input logic [47:0]        gyro_xyz,
	input logic [1:0]         format_used
);
	import gprm_pkg::*;

	// a stalled report holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(stick_lx) && $stable(button_bits)
			&& $stable(gyro_xyz) && $stable(format_used))
		else $error("stalled report changed");

	a_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> format_used != MODE_RSVD)
		else $error("reserved format reported");

	a_pack: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && format_used == MODE_PACK |->
			stick_lx[15:8] == 8'h00 && stick_ly[15:8] == 8'h00
			&& stick_rx[15:8] == 8'h00 && stick_ry[15:8] == 8'h00)
		else $error("packed stick out of range");

	a_hat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && button_bits[7:4] == 4'h0 |-> hat_dir == HAT_NEUTRAL)
		else $error("hat not neutral with no direction pressed");

endmodule

bind framed_gamepad_report_mapper gprm_checker u_gprm_checker (.*);

### tb/sv/framed_gamepad_report_mapper_tb.sv
`timescale 1ns / 1ps
module framed_gamepad_report_mapper_tb;
	import gprm_pkg::*;

	localparam int QuietLimit   = 2000;
	localparam int RxHoldCycles = 250;
	localparam int SettleCycles = 8;

	typedef struct packed {
		logic [15:0] lx;
		logic [15:0] ly;
		logic [15:0] rx;
		logic [15:0] ry;
		logic [7:0]  lt;
		logic [7:0]  rt;
		logic [15:0] btn;
		logic [3:0]  hat;
		logic [47:0] gyro;
		logic [47:0] accel;
		logic [1:0]  fmt;
	} report_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         rx_byte = 8'h00;
	logic               out_valid;
	logic               out_stall = 1'b1;
	logic signed [15:0] stick_lx;
	logic signed [15:0] stick_ly;
	logic signed [15:0] stick_rx;
	logic signed [15:0] stick_ry;
	logic [7:0]         left_trigger;
	logic [7:0]         right_trigger;
	logic [15:0]        button_bits;
	logic [3:0]         hat_dir;
	logic [47:0]        gyro_xyz;
	logic [47:0]        accel_xyz;
	logic [1:0]         format_used;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = CFG_DZ_L;
	logic [7:0]         cfg_data = 8'h00;

	// register copy
	logic [7:0] set_dz_left = 8'd5;
	logic [7:0] set_dz_right = 8'd5;
	logic       set_flip_lx = 1'b0;
	logic       set_flip_ly = 1'b1;
	logic       set_flip_rx = 1'b0;
	logic       set_flip_ry = 1'b1;
	logic [1:0] set_mode = MODE_S16;

	// parser copy
	logic [1:0] ph = PH_START;
	logic [5:0] flen = '0;
	logic [5:0] bidx = '0;
	logic [7:0] psum = '0;
	logic [7:0] pbuf [0:ReportLen-1];

	logic [7:0] tx_bytes [$];
	report_t    due_reports [$];
	logic [7:0] frame_body [0:MaxFrameLen-1];

	int  bytes_queued = 0;
	int  bytes_taken = 0;
	int  mismatches = 0;
	int  quiet_cycles = 0;
	int  tx_wait = 0;
	int  tx_run = 0;
	bit  tx_calm = 1'b0;
	bit  tx_burst = 1'b0;
	int  rx_wait = 0;
	int  rx_run = 0;
	bit  rx_calm = 1'b0;
	int  rx_hold_left = 0;
	bit  rx_hold_kick = 1'b0;
	bit  rx_hold_seen = 1'b0;

	framed_gamepad_report_mapper dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stick_lx(stick_lx),
		.stick_ly(stick_ly),
		.stick_rx(stick_rx),
		.stick_ry(stick_ry),
		.left_trigger(left_trigger),
		.right_trigger(right_trigger),
		.button_bits(button_bits),
		.hat_dir(hat_dir),
		.gyro_xyz(gyro_xyz),
		.accel_xyz(accel_xyz),
		.format_used(format_used),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [15:0] shape_stick(input logic [15:0] raw, input logic [7:0] dz,
			input logic flip, input logic [1:0] md);
		int          v;
		int          lim;
		logic [15:0] w;
		v = int'($signed(raw));
		lim = int'(dz) * DzFull / DzPct;
		if ((v < 0 ? -v : v) < lim)
			v = 0;
		if (flip) begin
			w = 16'(-v);
			v = int'($signed(w));
		end
		if (md == MODE_PACK)
			return {8'h00, 8'(v / 256 + 128)};
		return 16'(v);
	endfunction

	function automatic logic [3:0] hat_from_buttons(input logic [15:0] b);
		if (b[4])
			return b[6] ? HAT_UP_L : (b[7] ? HAT_UP_R : HAT_UP);
		if (b[5])
			return b[6] ? HAT_DN_L : (b[7] ? HAT_DN_R : HAT_DOWN);
		if (b[6])
			return HAT_LEFT;
		if (b[7])
			return HAT_RIGHT;
		return HAT_NEUTRAL;
	endfunction

	task automatic deframe_byte(input logic [7:0] ch);
		report_t    rep;
		logic [1:0] md;
		case (ph)
			PH_START: begin
				if (ch == START_MARK)
					ph = PH_LEN;
			end
			PH_LEN: begin
				flen = ch[5:0];
				bidx = '0;
				psum = '0;
				ph = (ch >= 1 && ch <= MaxFrameLen) ? PH_PAYLOAD : PH_START;
			end
			PH_PAYLOAD: begin
				if (bidx < ReportLen)
					pbuf[bidx] = ch;
				psum = psum + ch;
				bidx = bidx + 6'd1;
				if (bidx == flen)
					ph = PH_CHECK;
			end
			default: begin
				ph = PH_START;
				if (psum == ch && flen == ReportLen) begin
					md = (set_mode == MODE_RSVD) ? MODE_S16 : set_mode;
					rep.lx = shape_stick({pbuf[1], pbuf[0]}, set_dz_left, set_flip_lx, md);
					rep.ly = shape_stick({pbuf[3], pbuf[2]}, set_dz_left, set_flip_ly, md);
					rep.rx = shape_stick({pbuf[5], pbuf[4]}, set_dz_right, set_flip_rx, md);
					rep.ry = shape_stick({pbuf[7], pbuf[6]}, set_dz_right, set_flip_ry, md);
					rep.lt = pbuf[8];
					rep.rt = pbuf[9];
					rep.btn = {pbuf[11], pbuf[10]};
					rep.hat = hat_from_buttons(rep.btn);
					rep.gyro = {pbuf[17], pbuf[16], pbuf[15], pbuf[14], pbuf[13], pbuf[12]};
					rep.accel = {pbuf[23], pbuf[22], pbuf[21], pbuf[20], pbuf[19], pbuf[18]};
					rep.fmt = md;
					due_reports.push_back(rep);
				end
			end
		endcase
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= 8'h00;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid) begin
				deframe_byte(rx_byte);
				bytes_taken++;
				if (tx_run == 0) begin
					tx_run = $urandom_range(1, 40);
					tx_calm = ($urandom_range(0, 2) == 0);
				end
				tx_run--;
				tx_wait = (tx_calm || tx_burst) ? 0 : $urandom_range(0, 7);
			end
			if (tx_wait == 0 && tx_bytes.size() != 0) begin
				in_valid <= 1'b1;
				rx_byte <= tx_bytes.pop_front();
			end else begin
				in_valid <= 1'b0;
				if (tx_wait != 0)
					tx_wait--;
			end
		end
	end

	task automatic check_field(input string name, input logic [47:0] want,
			input logic [47:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t %s: expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	task automatic check_report();
		report_t rep;
		if (due_reports.size() == 0) begin
			mismatches++;
			$display("%0t unexpected report: expected none actual lx %0h btn %0h", $time,
				$unsigned(stick_lx), button_bits);
		end else begin
			rep = due_reports.pop_front();
			check_field("stick_lx", rep.lx, $unsigned(stick_lx));
			check_field("stick_ly", rep.ly, $unsigned(stick_ly));
			check_field("stick_rx", rep.rx, $unsigned(stick_rx));
			check_field("stick_ry", rep.ry, $unsigned(stick_ry));
			check_field("left_trigger", rep.lt, left_trigger);
			check_field("right_trigger", rep.rt, right_trigger);
			check_field("button_bits", rep.btn, button_bits);
			check_field("hat_dir", rep.hat, hat_dir);
			check_field("gyro_xyz", rep.gyro, gyro_xyz);
			check_field("accel_xyz", rep.accel, accel_xyz);
			check_field("format_used", rep.fmt, format_used);
		end
	endtask

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
		end else begin
			if (out_valid && !out_stall) begin
				check_report();
				if (rx_run == 0) begin
					rx_run = $urandom_range(1, 30);
					rx_calm = ($urandom_range(0, 2) == 0);
				end
				rx_run--;
				rx_wait = rx_calm ? 0 : $urandom_range(0, 7);
			end
			if (rx_hold_kick != rx_hold_seen) begin
				rx_hold_seen = rx_hold_kick;
				rx_hold_left = RxHoldCycles;
			end
			if (rx_hold_left != 0) begin
				rx_hold_left--;
				out_stall <= 1'b1;
			end else if (rx_wait != 0) begin
				out_stall <= 1'b1;
				if (out_valid)
					rx_wait--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QuietLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic push_byte(input logic [7:0] b);
		tx_bytes.push_back(b);
		bytes_queued++;
	endtask

	task automatic queue_frame(input int len, input logic [7:0] sum_xor);
		logic [7:0] sum;
		sum = 8'h00;
		push_byte(START_MARK);
		push_byte(8'(len));
		for (int i = 0; i < len; i++) begin
			push_byte(frame_body[i]);
			sum = sum + frame_body[i];
		end
		push_byte(sum ^ sum_xor);
	endtask

	task automatic fill_report(input logic [15:0] lx, input logic [15:0] ly,
			input logic [15:0] rx, input logic [15:0] ry, input logic [7:0] lt,
			input logic [7:0] rt, input logic [15:0] btn, input logic [47:0] gyro,
			input logic [47:0] accel);
		logic [191:0] flat;
		flat = {accel, gyro, btn, rt, lt, ry, rx, ly, lx};
		for (int i = 0; i < ReportLen; i++)
			frame_body[i] = flat[i*8 +: 8];
	endtask

	task automatic fill_random_body(input int len);
		for (int i = 0; i < len; i++)
			frame_body[i] = 8'($urandom);
	endtask

	function automatic logic [15:0] pick_stick(input logic [7:0] dz);
		int lim;
		int v;
		lim = int'(dz) * DzFull / DzPct;
		case ($urandom_range(0, 7))
			0: v = -32768;
			1: v = 32767;
			2: v = int'($urandom_range(0, 4)) - 2;
			3, 4: begin
				v = lim + int'($urandom_range(0, 2)) - 1;
				if ($urandom_range(0, 1) == 1)
					v = -v;
			end
			default: v = int'($urandom_range(0, 65535));
		endcase
		return 16'(v);
	endfunction

	function automatic logic [47:0] pick_motion();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return 48'({$urandom, $urandom});
		endcase
	endfunction

	task automatic fill_random_report();
		fill_report(pick_stick(set_dz_left), pick_stick(set_dz_left),
			pick_stick(set_dz_right), pick_stick(set_dz_right), 8'($urandom), 8'($urandom),
			16'($urandom), pick_motion(), pick_motion());
	endtask

	task automatic random_traffic(input int budget);
		int first;
		int kind;
		int len;
		first = bytes_queued;
		while (bytes_queued - first < budget) begin
			kind = $urandom_range(0, 99);
			if (kind < 65) begin
				fill_random_report();
				queue_frame(ReportLen, 8'h00);
			end else if (kind < 75) begin
				len = $urandom_range(1, MaxFrameLen);
				if (len == ReportLen)
					len++;
				fill_random_body(len);
				queue_frame(len, 8'h00);
			end else if (kind < 85) begin
				fill_random_report();
				queue_frame(ReportLen, 8'($urandom_range(1, 255)));
			end else if (kind < 92) begin
				repeat ($urandom_range(1, 4))
					push_byte(8'($urandom));
			end else if (kind < 96) begin
				push_byte(START_MARK);
				if ($urandom_range(0, 1) == 1)
					push_byte(8'h00);
				else
					push_byte(8'($urandom_range(MaxFrameLen + 1, 255)));
			end else begin
				// truncated frame, the next one runs into its payload
				push_byte(START_MARK);
				push_byte(8'(ReportLen));
				repeat ($urandom_range(1, ReportLen - 1))
					push_byte(8'($urandom));
			end
		end
	endtask

	task automatic drain();
		wait (bytes_taken == bytes_queued);
		wait (due_reports.size() == 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_DZ_L:    set_dz_left = val;
			CFG_DZ_R:    set_dz_right = val;
			CFG_FLIP_LX: set_flip_lx = val[0];
			CFG_FLIP_LY: set_flip_ly = val[0];
			CFG_FLIP_RX: set_flip_rx = val[0];
			CFG_FLIP_RY: set_flip_ry = val[0];
			CFG_MODE:    set_mode = val[1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [7:0] dzl, input logic [7:0] dzr,
			input logic flx, input logic fly, input logic frx, input logic fry,
			input logic [1:0] md);
		write_reg(CFG_DZ_L, dzl);
		write_reg(CFG_DZ_R, dzr);
		write_reg(CFG_FLIP_LX, {7'd0, flx});
		write_reg(CFG_FLIP_LY, {7'd0, fly});
		write_reg(CFG_FLIP_RX, {7'd0, frx});
		write_reg(CFG_FLIP_RY, {7'd0, fry});
		write_reg(CFG_MODE, {6'd0, md});
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h55);
		fill_report(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 8'h00, 8'hFF, 16'hFFFF, '1, '0);
		queue_frame(ReportLen, 8'h00);
		fill_report(16'd1638, 16'(-1638), 16'd1637, 16'(-1637), 8'hFF, 8'h00, 16'h0010,
			'0, '1);
		queue_frame(ReportLen, 8'h00);
		fill_report(16'h0000, 16'h0001, 16'hFFFF, 16'h8001, START_MARK, START_MARK, 16'h00A0,
			48'h0000_FFFF_8000, 48'h7FFF_0001_AAAA);
		queue_frame(ReportLen, 8'h00);
		// bad lengths, a start byte in the length slot is not a new start
		push_byte(START_MARK);
		push_byte(8'h00);
		push_byte(START_MARK);
		push_byte(8'(MaxFrameLen + 1));
		push_byte(START_MARK);
		push_byte(START_MARK);
		push_byte(START_MARK);
		push_byte(8'hFF);
		fill_report(16'h4000, 16'hC000, 16'h0100, 16'hFF00, 8'h01, 8'h80, 16'h0040,
			pick_motion(), pick_motion());
		queue_frame(ReportLen, 8'h00);
		// good sums on other lengths, then a bad and a good sum on report frames
		fill_random_body(1);
		queue_frame(1, 8'h00);
		fill_random_body(ReportLen - 1);
		queue_frame(ReportLen - 1, 8'h00);
		fill_random_body(ReportLen + 1);
		queue_frame(ReportLen + 1, 8'h00);
		fill_random_body(MaxFrameLen);
		queue_frame(MaxFrameLen, 8'h00);
		fill_random_report();
		queue_frame(ReportLen, 8'h01);
		fill_report(16'h0002, 16'hFFFE, 16'h1234, 16'hEDCC, 8'h7F, 8'hFE, 16'h0050,
			pick_motion(), pick_motion());
		queue_frame(ReportLen, 8'h00);
		random_traffic(100);
		drain();

		// back-pressure: receiver held off while frames keep coming
		apply_settings(8'd0, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1, MODE_HAT);
		tx_burst = 1'b1;
		rx_hold_kick = ~rx_hold_kick;
		repeat (12) begin
			fill_random_report();
			queue_frame(ReportLen, 8'h00);
		end
		drain();
		tx_burst = 1'b0;
		random_traffic(100);
		drain();

		apply_settings(8'd100, 8'd101, 1'b0, 1'b0, 1'b0, 1'b0, MODE_PACK);
		random_traffic(100);
		drain();

		apply_settings(8'($urandom_range(0, 120)), 8'($urandom_range(0, 120)), 1'($urandom),
			1'($urandom), 1'($urandom), 1'($urandom), MODE_RSVD);
		random_traffic(100);
		drain();

		repeat (4) begin
			apply_settings(8'($urandom_range(0, 120)), 8'($urandom), 1'($urandom),
				1'($urandom), 1'($urandom), 1'($urandom), 2'($urandom));
			random_traffic(100);
			drain();
		end

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
